// ===== src/iu2x_pkg.sv =====
// ----------------------------------------------------------------------------
// iu2x_pkg
// Shared constants and types of the 2x image upscaler.
// ----------------------------------------------------------------------------
package iu2x_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int PIXEL_BITS_DEF = 15;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int LW_W       = 13;
	localparam int FH_W       = 16;
	localparam int WT_W       = 16;
	localparam int OUT_X_W    = 13;
	localparam int OUT_Y_W    = 17;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_W_CENTER     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W_SIDE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W_DIAGONAL   = 3'd4;

	// register reset values
	localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 13'd4096;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd1024;
	localparam logic [WT_W-1:0] W_CENTER_RST     = 16'd36864;
	localparam logic [WT_W-1:0] W_SIDE_RST       = 16'd12288;
	localparam logic [WT_W-1:0] W_DIAGONAL_RST   = 16'd4096;

	// output row / column phase relative to the current input pixel
	localparam logic [1:0] PH_BEFORE = 2'd0; // row above / column to the left
	localparam logic [1:0] PH_MID    = 2'd1; // own row / column, first half
	localparam logic [1:0] PH_AFTER  = 2'd2; // own row / column, second half at the edge

	// which window pixels feed one output pixel
	typedef struct packed {
		logic ctr_top; // center row is the row above
		logic nb_top;  // neighbor row is the row above
		logic ctr_lft; // center column is the column to the left
		logic nb_lft;  // neighbor column is the column to the left
	} iu2x_sel_t;

endpackage

// ===== src/iu2x_ram.sv =====
// ----------------------------------------------------------------------------
// iu2x_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module iu2x_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/iu2x_interp.sv =====
// ----------------------------------------------------------------------------
// iu2x_interp
// Weighted sum of four window pixels for one output pixel, saturated.
// ----------------------------------------------------------------------------
module iu2x_interp #(
	parameter int PIXEL_BITS = iu2x_pkg::PIXEL_BITS_DEF
) (
	input  logic [PIXEL_BITS-1:0]      cur,
	input  logic [PIXEL_BITS-1:0]      left,
	input  logic [PIXEL_BITS-1:0]      up,
	input  logic [PIXEL_BITS-1:0]      upleft,
	input  iu2x_pkg::iu2x_sel_t        sel,
	input  logic [iu2x_pkg::WT_W-1:0]  w_center,
	input  logic [iu2x_pkg::WT_W-1:0]  w_side,
	input  logic [iu2x_pkg::WT_W-1:0]  w_diagonal,
	output logic [PIXEL_BITS-1:0]      value
);
	import iu2x_pkg::*;

	localparam int PC_W  = PIXEL_BITS + WT_W;
	localparam int PS_W  = PIXEL_BITS + WT_W + 1;
	localparam int ACC_W = PIXEL_BITS + WT_W + 2;
	localparam int HI_W  = ACC_W - WT_W;

	logic [PIXEL_BITS-1:0] p_ctr, p_sa, p_sb, p_diag;
	logic [PIXEL_BITS:0]   side_sum;
	logic [PC_W-1:0]       prod_c, prod_d;
	logic [PS_W-1:0]       prod_s;
	logic [ACC_W-1:0]      acc;
	logic [HI_W-1:0]       acc_hi;

	function automatic logic [PIXEL_BITS-1:0] pick(
		input logic top, input logic lft,
		input logic [PIXEL_BITS-1:0] c, input logic [PIXEL_BITS-1:0] l,
		input logic [PIXEL_BITS-1:0] u, input logic [PIXEL_BITS-1:0] ul
	);
		if (top) begin
			return lft ? ul : u;
		end
		return lft ? l : c;
	endfunction

	always_comb begin
		p_ctr  = pick(sel.ctr_top, sel.ctr_lft, cur, left, up, upleft);
		p_sa   = pick(sel.ctr_top, sel.nb_lft, cur, left, up, upleft);
		p_sb   = pick(sel.nb_top, sel.ctr_lft, cur, left, up, upleft);
		p_diag = pick(sel.nb_top, sel.nb_lft, cur, left, up, upleft);
		side_sum = {1'b0, p_sa} + {1'b0, p_sb};
		prod_c = PC_W'(w_center) * PC_W'(p_ctr);
		prod_s = PS_W'(w_side) * PS_W'(side_sum);
		prod_d = PC_W'(w_diagonal) * PC_W'(p_diag);
		acc    = ACC_W'(prod_c) + ACC_W'(prod_s) + ACC_W'(prod_d);
		// drop the fraction, clip at full scale
		acc_hi = acc[ACC_W-1:WT_W];
		if (|acc_hi[HI_W-1:PIXEL_BITS]) begin
			value = '1;
		end else begin
			value = acc_hi[PIXEL_BITS-1:0];
		end
	end

endmodule

// ===== src/image_upscale_2x.sv =====
// ----------------------------------------------------------------------------
// image_upscale_2x
// 2x grayscale upscaler on a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input pixels enter in raster order on in_valid/in_ready. Each input pixel
//   produces 1 to 9 output pixels on out_valid/out_ready, each tagged with its
//   output column (out_x) and row (out_y); last marks the final output of the
//   input pixel. Interior pixels give 4 outputs, pixels on the first row or
//   column fewer, pixels on the last row or column more.
//   Geometry and Q0.16 weights are written on the cfg channel (cfg_ready is
//   always high) while the block is idle.
//   Timing: a pixel passes the window stage and then the output register
//   before its first output is valid. Throughput is one output per cycle
//   while out_ready is high; interior pixels have 4 outputs, and the output
//   register is the limit. The next pixel is taken in the same cycle
//   that the last output of the current pixel moves to the output register.
//   The previous row sits in a line RAM of MAX_WIDTH entries.
//   Reset clears the counters, the left-neighbor register and the output
//   valid, and loads the register defaults. When the receiver stalls the
//   output register holds and input stops after one pending pixel.
// ----------------------------------------------------------------------------
module image_upscale_2x #(
	parameter int MAX_WIDTH  = iu2x_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = iu2x_pkg::PIXEL_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [iu2x_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [iu2x_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [PIXEL_BITS-1:0]            pixel,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [iu2x_pkg::OUT_X_W-1:0]     out_x,
	output logic [iu2x_pkg::OUT_Y_W-1:0]     out_y,
	output logic [PIXEL_BITS-1:0]            value,
	output logic                             last
);
	import iu2x_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam logic [AW:0] MAX_W = (AW+1)'(MAX_WIDTH);

	// configuration registers
	logic [LW_W-1:0] line_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [WT_W-1:0] w_center_q, w_side_q, w_diagonal_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			w_center_q     <= W_CENTER_RST;
			w_side_q       <= W_SIDE_RST;
			w_diagonal_q   <= W_DIAGONAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINE_WIDTH:   line_width_q   <= cfg_data[LW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_W_CENTER:     w_center_q     <= cfg_data[WT_W-1:0];
				REG_W_SIDE:       w_side_q       <= cfg_data[WT_W-1:0];
				REG_W_DIAGONAL:   w_diagonal_q   <= cfg_data[WT_W-1:0];
				default: ;
			endcase
		end
	end

	// frame position of the next input pixel
	logic [AW-1:0]         x_cnt_q;
	logic [FH_W-1:0]       y_cnt_q;
	logic [PIXEL_BITS-1:0] left_cur_q;

	logic [AW:0]   w_eff, x_inc;
	logic [FH_W:0] y_inc;
	logic          last_col_in, last_row_in, accept;

	always_comb begin
		if (line_width_q == '0) begin
			w_eff = (AW+1)'(1);
		end else if (32'(line_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = MAX_W;
		end else begin
			w_eff = (AW+1)'(line_width_q);
		end
		x_inc       = {1'b0, x_cnt_q} + (AW+1)'(1);
		y_inc       = {1'b0, y_cnt_q} + (FH_W+1)'(1);
		last_col_in = (x_inc >= w_eff);
		last_row_in = (y_inc >= {1'b0, frame_height_q});
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_cnt_q    <= '0;
			y_cnt_q    <= '0;
			left_cur_q <= '0;
		end else if (accept) begin
			left_cur_q <= pixel;
			if (last_col_in) begin
				x_cnt_q <= '0;
				y_cnt_q <= last_row_in ? '0 : y_inc[FH_W-1:0];
			end else begin
				x_cnt_q <= x_inc[AW-1:0];
			end
		end
	end

	// line RAM: read the pixel above and overwrite it in the same transaction
	logic [PIXEL_BITS-1:0] above;

	iu2x_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (x_cnt_q),
		.wdata (pixel),
		.re    (accept),
		.raddr (x_cnt_q),
		.rdata (above)
	);

	// window stage: held while its outputs are sent
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] cur_s1, left_s1, upleft_s1;
	logic [AW-1:0]         x_s1;
	logic [FH_W-1:0]       y_s1;
	logic                  last_col_s1, last_row_s1;
	logic [1:0]            rph_q, cph_q;

	logic emit, advance, col_done, row_done, item_done, has_up, has_left;

	assign has_up   = (y_s1 != '0);
	assign has_left = (x_s1 != '0);
	assign col_done = (cph_q == PH_AFTER) || (cph_q == PH_MID && !last_col_s1);
	assign row_done = (rph_q == PH_AFTER) || (rph_q == PH_MID && !last_row_s1);
	assign item_done = col_done && row_done;

	assign advance  = !out_valid || out_ready;
	assign emit     = valid_s1 && advance;
	assign in_ready = !valid_s1 || (emit && item_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rph_q    <= PH_MID;
			cph_q    <= PH_MID;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			rph_q    <= (y_cnt_q != '0) ? PH_BEFORE : PH_MID;
			cph_q    <= (x_cnt_q != '0) ? PH_BEFORE : PH_MID;
		end else if (emit) begin
			if (item_done) begin
				valid_s1 <= 1'b0;
			end else if (!col_done) begin
				cph_q <= cph_q + 2'd1;
			end else begin
				// wrap to the first column of the next output row
				cph_q <= has_left ? PH_BEFORE : PH_MID;
				rph_q <= rph_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= pixel;
			left_s1     <= left_cur_q;
			upleft_s1   <= above; // still the pixel above the previous input
			x_s1        <= x_cnt_q;
			y_s1        <= y_cnt_q;
			last_col_s1 <= last_col_in;
			last_row_s1 <= last_row_in;
		end
	end

	// output pixel geometry
	iu2x_sel_t             sel;
	logic [31:0]           ox_full;
	logic [OUT_Y_W-1:0]    oy;
	logic [PIXEL_BITS-1:0] value_d;

	always_comb begin
		sel.ctr_top = (rph_q == PH_BEFORE);
		sel.nb_top  = (rph_q == PH_MID) && has_up;
		sel.ctr_lft = (cph_q == PH_BEFORE);
		sel.nb_lft  = (cph_q == PH_MID) && has_left;
		case (cph_q)
			PH_BEFORE: ox_full = {31'(x_s1), 1'b0} - 32'd1;
			PH_AFTER:  ox_full = {31'(x_s1), 1'b1};
			default:   ox_full = {31'(x_s1), 1'b0};
		endcase
		case (rph_q)
			PH_BEFORE: oy = {y_s1, 1'b0} - OUT_Y_W'(1);
			PH_AFTER:  oy = {y_s1, 1'b1};
			default:   oy = {y_s1, 1'b0};
		endcase
	end

	iu2x_interp #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_interp (
		.cur        (cur_s1),
		.left       (left_s1),
		.up         (above),
		.upleft     (upleft_s1),
		.sel        (sel),
		.w_center   (w_center_q),
		.w_side     (w_side_q),
		.w_diagonal (w_diagonal_q),
		.value      (value_d)
	);

	// output register
	logic                  out_valid_q, last_q;
	logic [OUT_X_W-1:0]    out_x_q;
	logic [OUT_Y_W-1:0]    out_y_q;
	logic [PIXEL_BITS-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q <= ox_full[OUT_X_W-1:0];
			out_y_q <= oy;
			value_q <= value_d;
			last_q  <= item_done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

// ===== tb/sv/image_upscale_2x_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_upscale_2x_tb
// Self-checking bench for the 2x grayscale upscaler.
// Pixels go in on a valid/ready stream. A local model of the upscaler works
// out every output pixel, with its coordinates and end flag, for each accepted
// pixel. A checker compares each output transaction with the oldest expected
// one. Directed cases cover reset defaults, corners with saturation,
// degenerate and changed geometry, and unused register indexes. Random
// frames, a long output stall and a row written wider than the maximum follow.
// ----------------------------------------------------------------------------
module image_upscale_2x_tb;
	import iu2x_pkg::*;

	localparam int               MAX_W       = MAX_WIDTH_DEF;
	localparam int               PIX_W       = PIXEL_BITS_DEF;
	localparam logic [PIX_W-1:0] PIX_MAX     = '1;
	localparam int               LIMIT       = 400000;
	localparam int               HOLD_CYCLES = 300;
	localparam int               END_CYCLES  = 8;
	localparam int               WIDE_PIXELS = 40;

	// no register lives at these indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 3'd5;

	typedef struct packed {
		logic [OUT_X_W-1:0] x;
		logic [OUT_Y_W-1:0] y;
		logic [PIX_W-1:0]   v;
		logic               lst;
	} upscaled_px_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel     = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OUT_X_W-1:0]    out_x;
	logic [OUT_Y_W-1:0]    out_y;
	logic [PIX_W-1:0]      value;
	logic                  last;

	// upscaler model state and its copy of the registers
	logic [LW_W-1:0]  width_reg  = LINE_WIDTH_RST;
	logic [FH_W-1:0]  height_reg = FRAME_HEIGHT_RST;
	logic [WT_W-1:0]  wc_reg     = W_CENTER_RST;
	logic [WT_W-1:0]  ws_reg     = W_SIDE_RST;
	logic [WT_W-1:0]  wd_reg     = W_DIAGONAL_RST;
	logic [PIX_W-1:0] line_mem [MAX_W];
	logic [PIX_W-1:0] left_px    = '0;
	logic [PIX_W-1:0] up_left_px = '0;
	int unsigned      col_pos    = 0;
	logic [15:0]      row_pos    = '0;

	// 2x2 window around the newest pixel
	logic [PIX_W-1:0] nb_c, nb_l, nb_u, nb_ul;
	int               nb_row, nb_col;

	upscaled_px_t pending_outputs [$];
	int error_count   = 0;
	int send_idle_pct = 13;
	int recv_idle_pct = 13;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int timeout_cycles;

	image_upscale_2x u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.value     (value),
		.last      (last)
	);

	always #4 clk = ~clk;

	// clamp to the frame edge, then pick from the window
	function automatic logic [PIX_W-1:0] tap(int r, int c);
		if (r < 0) r = 0;
		if (r > nb_row) r = nb_row;
		if (c < 0) c = 0;
		if (c > nb_col) c = nb_col;
		if (r != nb_row) return (c != nb_col) ? nb_ul : nb_u;
		return (c != nb_col) ? nb_l : nb_c;
	endfunction

	function automatic logic [PIX_W-1:0] mix_taps(int r, int dy, int c, int dx);
		int sy, sx;
		logic [63:0] acc;
		sy = dy ? 1 : -1;
		sx = dx ? 1 : -1;
		acc = 64'(wc_reg) * tap(r, c)
			+ 64'(ws_reg) * (64'(tap(r, c + sx)) + 64'(tap(r + sy, c)))
			+ 64'(wd_reg) * tap(r + sy, c + sx);
		acc = acc >> 16;
		if (acc > PIX_MAX) return PIX_MAX;
		return acc[PIX_W-1:0];
	endfunction

	// queue every output pixel that the accepted input pixel completes
	task automatic expand_pixel(input logic [PIX_W-1:0] p);
		int unsigned w, x, y;
		logic [PIX_W-1:0] above;
		bit end_col, end_row;
		int rr[3], rd[3], cc[3], cd[3];
		int nr, nc;
		upscaled_px_t px;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		x = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
		y = row_pos;
		end_col = (x + 1 >= w);
		end_row = (y + 1 >= height_reg);
		above = line_mem[x];
		nb_c = p;
		nb_l = left_px;
		nb_u = above;
		nb_ul = up_left_px;
		nb_row = y;
		nb_col = x;
		nr = 0;
		nc = 0;
		if (y >= 1) begin
			rr[nr] = y - 1; rd[nr] = 1; nr++;
		end
		rr[nr] = y; rd[nr] = 0; nr++;
		if (end_row) begin
			rr[nr] = y; rd[nr] = 1; nr++;
		end
		if (x >= 1) begin
			cc[nc] = x - 1; cd[nc] = 1; nc++;
		end
		cc[nc] = x; cd[nc] = 0; nc++;
		if (end_col) begin
			cc[nc] = x; cd[nc] = 1; nc++;
		end
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				px.x = OUT_X_W'(cc[j] * 2 + cd[j]);
				px.y = OUT_Y_W'(rr[i] * 2 + rd[i]);
				px.v = mix_taps(rr[i], rd[i], cc[j], cd[j]);
				px.lst = (i == nr - 1) && (j == nc - 1);
				pending_outputs.push_back(px);
			end
		end
		up_left_px = above;
		line_mem[x] = p;
		left_px = p;
		if (end_col) begin
			col_pos = 0;
			row_pos = end_row ? 16'd0 : 16'(y + 1);
		end else begin
			col_pos = x + 1;
		end
	endtask

	// cfg_valid stays high afterwards; the next send or drain drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
		REG_LINE_WIDTH: begin
			width_reg = data[LW_W-1:0];
		end
		REG_FRAME_HEIGHT: begin
			height_reg = data[FH_W-1:0];
		end
		REG_W_CENTER: begin
			wc_reg = data[WT_W-1:0];
		end
		REG_W_SIDE: begin
			ws_reg = data[WT_W-1:0];
		end
		REG_W_DIAGONAL: begin
			wd_reg = data[WT_W-1:0];
		end
		default: begin
		end
		endcase
	endtask

	task automatic write_weights(input logic [WT_W-1:0] c, input logic [WT_W-1:0] s,
			input logic [WT_W-1:0] d);
		write_reg(REG_W_CENTER, c);
		write_reg(REG_W_SIDE, s);
		write_reg(REG_W_DIAGONAL, d);
	endtask

	task automatic write_geometry(input logic [CFG_DATA_W-1:0] w,
			input logic [CFG_DATA_W-1:0] h);
		write_reg(REG_LINE_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// valid stays high on return so back-to-back pixels need no extra edge
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expand_pixel(p);
	endtask

	task automatic wait_drain();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return PIX_MAX;
		default: return PIX_W'($urandom_range(0, PIX_MAX));
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_pixel('0);
		send_pixel(PIX_MAX);
		send_pixel(15'd12345);
		// shrink the row mid-frame: the current column becomes the last one
		wait_drain();
		write_reg(REG_LINE_WIDTH, 16'd1);
		send_pixel(15'h5555);
		// shrink the frame below the current row: this row closes the frame
		wait_drain();
		write_reg(REG_FRAME_HEIGHT, 16'd1);
		send_pixel(15'h2AAA);
	endtask

	// every corner and edge of a 3x3 frame, full weights to force saturation
	task automatic test_saturating_corners();
		wait_drain();
		write_geometry(16'd3, 16'd3);
		write_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(PIX_MAX);
		send_pixel('0);
		send_pixel(15'h5555);
		send_pixel(15'h2AAA);
		send_pixel(15'd1);
		send_pixel(PIX_MAX);
		send_pixel('0);
		send_pixel(15'h4000);
		send_pixel(15'd3);
	endtask

	task automatic test_degenerate_geometry();
		wait_drain();
		// zero width and height act as one
		write_geometry(16'd0, 16'd0);
		write_weights(16'd0, 16'd0, 16'd0);
		send_pixel(PIX_MAX);
		wait_drain();
		write_weights(16'd34953, 16'd8738, 16'd13107);
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_UNUSED_LOW, 16'd2);
		send_pixel(15'd777);
	endtask

	task automatic test_tall_frame_shrink();
		wait_drain();
		write_geometry(16'd2, 16'hFFFF);
		write_weights(W_CENTER_RST, W_SIDE_RST, W_DIAGONAL_RST);
		repeat (4) send_pixel(rand_pixel());
		// row two is past the new height, so it closes the frame
		wait_drain();
		write_reg(REG_FRAME_HEIGHT, 16'd1);
		repeat (2) send_pixel(rand_pixel());
	endtask

	task automatic write_random_blend();
		case ($urandom_range(0, 4))
		0: write_weights(W_CENTER_RST, W_SIDE_RST, W_DIAGONAL_RST);
		1: write_weights(16'd34953, 16'd8738, 16'd13107);
		2: write_weights(WT_W'($urandom_range(0, 16'hFFFF)),
				WT_W'($urandom_range(0, 16'hFFFF)),
				WT_W'($urandom_range(0, 16'hFFFF)));
		default: write_weights(WT_W'($urandom_range(0, 16'h3FFF)),
				WT_W'($urandom_range(0, 16'h3FFF)),
				WT_W'($urandom_range(0, 16'h3FFF)));
		endcase
	endtask

	task automatic test_random_frames(input int unsigned n_items);
		int unsigned sent, w, h;
		sent = 0;
		while (sent < n_items) begin
			wait_drain();
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
			h = $urandom_range(1, 5);
			write_geometry(16'(w), 16'(h));
			if ($urandom_range(0, 2) == 0) write_random_blend();
			repeat (w * h) send_pixel(rand_pixel());
			sent += w * h;
		end
	endtask

	// receiver holds off while the sender keeps offering pixels
	task automatic test_output_stall();
		wait_drain();
		write_geometry(16'd6, 16'd5);
		write_random_blend();
		hold_requests++;
		repeat (30) send_pixel(rand_pixel());
	endtask

	// width written above the range so it clamps; no idling on either side,
	// then shrink the row so the current column closes it
	task automatic test_wide_row();
		wait_drain();
		write_geometry(16'd8191, 16'd1);
		write_weights(W_CENTER_RST, W_SIDE_RST, W_DIAGONAL_RST);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (WIDE_PIXELS) send_pixel(rand_pixel());
		wait_drain();
		write_reg(REG_LINE_WIDTH, 16'd4);
		send_pixel(rand_pixel());
		wait_drain();
		send_idle_pct = 13;
		recv_idle_pct = 13;
	endtask

	always @(posedge clk) begin
		upscaled_px_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected output: x=%0d y=%0d value=%0d last=%0b",
						out_x, out_y, value, last);
			end else begin
				want = pending_outputs.pop_front();
				if (out_x !== want.x || out_y !== want.y || value !== want.v
						|| last !== want.lst) begin
					error_count++;
					if (error_count <= 10)
						$display({"mismatch: expected x=%0d y=%0d value=%0d last=%0b,",
							" got x=%0d y=%0d value=%0d last=%0b"},
							want.x, want.y, want.v, want.lst, out_x, out_y, value, last);
				end
			end
		end
		if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		for (timeout_cycles = 0; timeout_cycles < LIMIT; timeout_cycles++)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		for (int i = 0; i < MAX_W; i++) line_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_saturating_corners();
		test_degenerate_geometry();
		test_tall_frame_shrink();
		test_random_frames(180);
		test_output_stall();
		test_wide_row();
		wait_drain();
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_outputs.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
